>>> hdl/mi_pkg.sv
// Package with shared constants and types for the modular inverse block.
package mi_pkg;

    localparam int unsigned MI_WORD_BITS     = 32;
    localparam logic [63:0] MI_MODULUS_RESET = 64'd1000000007;
    localparam int unsigned MI_REG_MODULUS   = 0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ALIGN,
        ST_SUB,
        ST_FINAL,
        ST_DONE
    } t_state;

endpackage

>>> hdl/mi_if.sv
// Valid/ready stream interfaces for the input value and the resulting inverse.
interface mi_value_if #(
    parameter int unsigned W = 32
);
    logic         valid;
    logic         ready;
    logic [W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface mi_inverse_if #(
    parameter int unsigned W = 32
);
    logic         valid;
    logic         ready;
    logic [W-1:0] inverse;

    modport source (output valid, output inverse, input ready);
    modport sink   (input valid, input inverse, output ready);
endinterface

>>> hdl/mi_apb_regs.sv
// APB register file holding the modulus.
module mi_apb_regs
    import mi_pkg::*;
#(
    parameter int unsigned WORD_BITS = MI_WORD_BITS,
    parameter int unsigned DATA_W    = (WORD_BITS > 32) ? 64 : 32,
    parameter int unsigned ADDR_W    = $clog2(DATA_W / 8) + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    output logic [WORD_BITS-1:0] o_modulus
);

    localparam logic IDX_MODULUS = 1'(MI_REG_MODULUS);

    logic [WORD_BITS-1:0] r_modulus;
    logic                 sel_modulus;

    assign sel_modulus = (paddr[ADDR_W-1] == IDX_MODULUS);
    assign pready      = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MI_MODULUS_RESET[WORD_BITS-1:0];
        end else if (psel && penable && pwrite && sel_modulus) begin
            r_modulus <= pwdata[WORD_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_modulus) begin
            prdata[WORD_BITS-1:0] = r_modulus;
        end
    end

    assign o_modulus = r_modulus;

endmodule

>>> hdl/mi_euclid_seq.sv
// Sequencer and shared compare/subtract datapath for extended Euclid.
module mi_euclid_seq
    import mi_pkg::*;
#(
    parameter int unsigned WORD_BITS = MI_WORD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [WORD_BITS-1:0] i_modulus,
    mi_value_if.sink             i_value,
    output logic                 o_res_valid,
    output logic [WORD_BITS-1:0] o_res_data,
    input  logic                 i_res_ready
);

    localparam int unsigned W     = WORD_BITS;
    localparam int unsigned CW    = W + 2;
    localparam int unsigned CNT_W = $clog2(W);

    t_state r_state, n_state;

    logic [W-1:0]     r_r0, n_r0, r_r1, n_r1;
    logic [CW-1:0]    r_c0, n_c0, r_c1, n_c1;
    logic [W-1:0]     r_rem, n_rem, r_dr, n_dr;
    logic [CW-1:0]    r_cc, n_cc, r_dc, n_dc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]     r_res, n_res;

    // Shared compare/subtract unit: remainder against the (possibly doubled) divisor.
    logic [W+1:0]  alu_b;
    logic [W+1:0]  alu_diff;
    logic          alu_ge;
    logic [CW-1:0] cc_sub;

    // Final reduction into the range of the modulus.
    logic          c0_neg;
    logic [CW-1:0] c0_mag;
    logic [CW-1:0] mod_ext;
    logic [CW-1:0] red;

    assign alu_b    = (r_state == ST_ALIGN) ? {1'b0, r_dr, 1'b0} : {2'b00, r_dr};
    assign alu_diff = {2'b00, r_rem} - alu_b;
    assign alu_ge   = !alu_diff[W+1];
    assign cc_sub   = r_cc - r_dc;

    assign c0_neg  = r_c0[CW-1];
    assign c0_mag  = c0_neg ? (CW'(0) - r_c0) : r_c0;
    assign mod_ext = {2'b00, i_modulus};
    assign red     = (c0_mag >= mod_ext) ? (c0_mag - mod_ext) : c0_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r0  <= n_r0;
        r_r1  <= n_r1;
        r_c0  <= n_c0;
        r_c1  <= n_c1;
        r_rem <= n_rem;
        r_cc  <= n_cc;
        r_dr  <= n_dr;
        r_dc  <= n_dc;
        r_cnt <= n_cnt;
        r_res <= n_res;
    end

    always_comb begin
        n_state       = r_state;
        n_r0          = r_r0;
        n_r1          = r_r1;
        n_c0          = r_c0;
        n_c1          = r_c1;
        n_rem         = r_rem;
        n_cc          = r_cc;
        n_dr          = r_dr;
        n_dc          = r_dc;
        n_cnt         = r_cnt;
        n_res         = r_res;
        i_value.ready = 1'b0;
        o_res_valid   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                i_value.ready = 1'b1;
                if (i_value.valid) begin
                    n_r0    = i_value.value;
                    n_r1    = i_modulus;
                    n_c0    = CW'(1);
                    n_c1    = '0;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_r1 == '0) begin
                    n_state = ST_FINAL;
                end else begin
                    n_rem   = r_r0;
                    n_cc    = r_c0;
                    n_dr    = r_r1;
                    n_dc    = r_c1;
                    n_cnt   = '0;
                    n_state = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                if (alu_ge) begin
                    n_dr  = {r_dr[W-2:0], 1'b0};
                    n_dc  = {r_dc[CW-2:0], 1'b0};
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    n_state = ST_SUB;
                end
            end
            ST_SUB: begin
                if (alu_ge) begin
                    n_rem = alu_diff[W-1:0];
                    n_cc  = cc_sub;
                end
                if (r_cnt == '0) begin
                    n_r0    = r_r1;
                    n_r1    = n_rem;
                    n_c0    = r_c1;
                    n_c1    = n_cc;
                    n_state = ST_CHECK;
                end else begin
                    n_dr  = {1'b0, r_dr[W-1:1]};
                    n_dc  = {r_dc[CW-1], r_dc[CW-1:1]};
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_FINAL: begin
                if (i_modulus == '0) begin
                    n_res = '0;
                end else if (c0_neg && (red != '0)) begin
                    n_res = i_modulus - red[W-1:0];
                end else if (c0_neg) begin
                    n_res = '0;
                end else begin
                    n_res = red[W-1:0];
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res_data = r_res;

endmodule

>>> hdl/mi_out_reg.sv
// Output register that holds one finished inverse until it is taken.
module mi_out_reg
    import mi_pkg::*;
#(
    parameter int unsigned WORD_BITS = MI_WORD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_res_valid,
    input  logic [WORD_BITS-1:0] i_res_data,
    output logic                 o_res_ready,
    mi_inverse_if.source         o_inverse
);

    logic                 r_valid;
    logic [WORD_BITS-1:0] r_data;

    assign o_res_ready = !r_valid || o_inverse.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_data <= i_res_data;
        end
    end

    assign o_inverse.valid   = r_valid;
    assign o_inverse.inverse = r_data;

endmodule

>>> hdl/modular_inverse_top.sv
// Steps from the input transfer to the result in a free output register: a check, then per
// Euclid round the divisor alignment and the quotient-bit subtraction, then the final reduction.
// The shared remainder compare/subtract unit does one alignment or one quotient bit a cycle.
// One value is worked on at a time; a new value is taken in the cycle after the previous
// result has moved into the output register, which may still wait.
// Reset (synchronous, active low) returns the sequencer to idle and sets modulus 1000000007.
module modular_inverse_top
    import mi_pkg::*;
#(
    parameter int unsigned WORD_BITS = MI_WORD_BITS,
    parameter int unsigned DATA_W    = (WORD_BITS > 32) ? 64 : 32,
    parameter int unsigned ADDR_W    = $clog2(DATA_W / 8) + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    mi_value_if.sink          i_value,
    mi_inverse_if.source      o_inverse
);

    logic [WORD_BITS-1:0] modulus;
    logic                 res_valid;
    logic                 res_ready;
    logic [WORD_BITS-1:0] res_data;

    mi_apb_regs #(
        .WORD_BITS (WORD_BITS),
        .DATA_W    (DATA_W),
        .ADDR_W    (ADDR_W)
    ) u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_modulus (modulus)
    );

    mi_euclid_seq #(
        .WORD_BITS (WORD_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_modulus   (modulus),
        .i_value     (i_value),
        .o_res_valid (res_valid),
        .o_res_data  (res_data),
        .i_res_ready (res_ready)
    );

    mi_out_reg #(
        .WORD_BITS (WORD_BITS)
    ) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res_data  (res_data),
        .o_res_ready (res_ready),
        .o_inverse   (o_inverse)
    );

endmodule

>>> hdl/mi_checker.sv
// Port-level checker for the modular inverse block and its bind to the top level.
module mi_checker
    import mi_pkg::*;
#(
    parameter int unsigned W = MI_WORD_BITS
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_valid,
    input logic         i_in_ready,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic [W-1:0] i_out_inverse,
    input logic         i_pready
);

    // The sequencer is busy, with input ready low, right after taking a value.
    a_busy_after_transfer: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready
    ) else $error("input ready right after an input transfer");

    a_empty_after_reset: assert property (
        @(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid
    ) else $error("result valid right after reset");

    a_pready_high: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_pready
    ) else $error("pready low");

    a_result_held: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_inverse))
    ) else $error("stalled result changed");

endmodule

bind modular_inverse_top mi_checker #(
    .W (WORD_BITS)
) u_mi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_value.valid),
    .i_in_ready    (i_value.ready),
    .i_out_valid   (o_inverse.valid),
    .i_out_ready   (o_inverse.ready),
    .i_out_inverse (o_inverse.inverse),
    .i_pready      (pready)
);
